>>> rtl/core/sync_length_frame_deframer_unit_defines.svh
// Assertion macros shared by the checker of the sync/length frame deframer.
// No dependencies; included by files that assert.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SLFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slfd implication check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SLFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slfd next-cycle check failed");

`endif

>>> rtl/core/slfd_pkg.sv
// Package for the sync/length frame deframer: widths, limits, register
// indexes and the types passed between its modules. No dependencies.
`default_nettype none

package slfd_pkg;

   localparam int BYTE_W         = 8;
   localparam int POS_W          = 6;
   localparam int PC_W           = 8;
   localparam int POSITION_LIMIT = 51;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 8;
   localparam int REQ_DATA_W     = 8;
   localparam int RSP_DATA_W     = 16;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hff;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_FIRST  = 1'b0,
      CSR_SYNC_SECOND = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] payload_byte;
      logic [POS_W-1:0]  payload_position;
      logic              frame_done;
      logic              frame_aborted;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/core/slfd_csr.sv
// Configuration registers of the deframer (sync byte pair).
// Depends on slfd_pkg.
`default_nettype none

module slfd_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [slfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [slfd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output slfd_pkg::cfg_type                    cfg
);
   import slfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_wdata[BYTE_W-1:0];
            CSR_SYNC_SECOND: cfg_in.sync_second = csr_wdata[BYTE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= SYNC_FIRST_RESET;
         cfg_ff.sync_second <= SYNC_SECOND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/slfd_core.sv
// Frame parser state and its per-byte update: sync detection, length capture,
// payload counting, completion and abort. Depends on slfd_pkg.
`default_nettype none

module slfd_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step_en,
   input  wire logic [slfd_pkg::BYTE_W-1:0] rx_byte,
   input  slfd_pkg::cfg_type                cfg,
   output slfd_pkg::result_type             res
);
   import slfd_pkg::*;

   localparam logic [PC_W-1:0] LIMIT = PC_W'(POSITION_LIMIT);

   logic              in_frame_ff, in_frame_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [BYTE_W-1:0] remaining_ff, remaining_in;
   logic [PC_W-1:0]   pc_step;
   logic [PC_W-1:0]   pc_inc;
   logic              emit;
   logic [POS_W-1:0]  pos;
   logic              done;
   logic              aborted;

   always_comb begin
      in_frame_in  = in_frame_ff;
      prev_in      = prev_ff;
      remaining_in = remaining_ff;
      pc_step      = pc_ff;
      emit         = 1'b0;
      pos          = '0;
      done         = 1'b0;
      aborted      = 1'b0;

      // A second sync byte seen while idle never becomes the remembered byte.
      if (!in_frame_ff && (rx_byte == cfg.sync_second)) begin
         if (prev_ff == cfg.sync_first) begin
            pc_step     = PC_W'(1);
            in_frame_in = 1'b1;
         end
      end else begin
         prev_in = rx_byte;
         if (in_frame_ff) begin
            if (pc_ff == PC_W'(2)) begin
               remaining_in = rx_byte;
            end else if (pc_ff > PC_W'(2)) begin
               remaining_in = remaining_ff - BYTE_W'(1);
               emit         = 1'b1;
               pos          = POS_W'(pc_ff - PC_W'(2));
            end
         end
      end

      pc_inc = pc_step + PC_W'(1);
      pc_in  = pc_inc;

      // The counter also runs while idle and wraps to zero past the limit.
      if (pc_inc > LIMIT) begin
         pc_in       = '0;
         aborted     = in_frame_in;
         in_frame_in = 1'b0;
      end

      if (in_frame_in && (remaining_in == '0) && (pc_in > PC_W'(3))) begin
         in_frame_in = 1'b0;
         pc_in       = '0;
         done        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         prev_ff      <= '0;
         pc_ff        <= '0;
         remaining_ff <= '0;
      end else if (step_en) begin
         in_frame_ff  <= in_frame_in;
         prev_ff      <= prev_in;
         pc_ff        <= pc_in;
         remaining_ff <= remaining_in;
      end
   end

   assign res.valid            = emit;
   assign res.payload_byte     = rx_byte;
   assign res.payload_position = pos;
   assign res.frame_done       = done;
   assign res.frame_aborted    = aborted;

endmodule

`default_nettype wire

>>> rtl/core/sync_length_frame_deframer_unit.sv
// Sync/length frame deframer. Takes one received byte per transaction and
// finds frames that start with the configured two-byte sync pair, followed
// by a length byte and the payload. Each payload byte leaves as one result
// transaction with its position from 1; tlast marks the byte that completes
// the frame and tuser marks a frame dropped at the position limit. Header
// and idle bytes give no result. A byte can be accepted every cycle: it is
// held in an input register and processed by the parser once the output
// register is free, and its result is loaded into the output register, from
// which it can be taken as soon as it shows. Throughput drops only while the
// output register holds a result that the downstream side has not taken;
// the input register then keeps taking one more byte. The user must write the
// sync bytes through the csr_ port only while no byte is in flight; the block
// itself does not enforce this. Depends on slfd_pkg, slfd_csr and slfd_core.
`default_nettype none

module sync_length_frame_deframer_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Received byte stream. tdata: [7:0] rx_byte.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [slfd_pkg::REQ_DATA_W-1:0] req_tdata,
   // Payload stream. tdata: [7:0] payload_byte, [13:8] payload_position,
   // [15:14] zero. tlast: frame_done. tuser: frame_aborted.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [slfd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser,
   // Configuration writes.
   input  wire logic                            csr_we,
   input  wire logic [slfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [slfd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import slfd_pkg::*;

   cfg_type           cfg;
   result_type        res;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   logic              req_accept;
   logic              proc_fire;

   slfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slfd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (proc_fire),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .res     (res)
   );

   // The held byte is processed only when the output register is free.
   assign proc_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_fire;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (proc_fire) begin
         rsp_valid_in = res.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata[BYTE_W-1:0];
      end
      if (proc_fire) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - BYTE_W - POS_W)'(0),
                        rsp_data_ff.payload_position,
                        rsp_data_ff.payload_byte};
   assign rsp_tlast  = rsp_data_ff.frame_done;
   assign rsp_tuser  = rsp_data_ff.frame_aborted;

endmodule

`default_nettype wire

>>> rtl/core/slfd_checker.sv
// Port-level checks for the sync/length frame deframer and their binding.
// Depends on slfd_pkg and sync_length_frame_deframer_unit_defines.svh.
`default_nettype none

`include "sync_length_frame_deframer_unit_defines.svh"

module slfd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [slfd_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [slfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tlast,
   input wire logic                            rsp_tuser,
   input wire logic                            csr_we,
   input wire logic [slfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input wire logic [slfd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import slfd_pkg::*;

   logic unused_inputs;
   assign unused_inputs = ^{req_tvalid, req_tready, req_tdata, csr_we, csr_index, csr_wdata};

   // A stalled result keeps its payload.
   `SLFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
   // Payload positions count from one.
   `SLFD_ASSERT_IMPL(a_pos_nonzero, clock, reset, rsp_tvalid, rsp_tdata[BYTE_W+POS_W-1:BYTE_W] != '0)
   // A frame cannot both complete and be dropped on the same byte.
   `SLFD_ASSERT_IMPL(a_done_xor_abort, clock, reset, rsp_tvalid, !(rsp_tlast && rsp_tuser))
   // The padding bits above the position stay zero.
   `SLFD_ASSERT_IMPL(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:BYTE_W+POS_W] == '0)
   // No result is shown in the cycle after reset.
   `SLFD_ASSERT_IMPL(a_reset_quiet, clock, reset, $fell(reset), !rsp_tvalid)

endmodule

bind sync_length_frame_deframer_unit slfd_checker u_slfd_checker (.*);

`default_nettype wire
